[sv/msqrt_pkg.sv]
//------------------------------------------------------------------------------
// msqrt_pkg
// Shared types and codes for the modular square root unit.
//------------------------------------------------------------------------------
`default_nettype none
package msqrt_pkg;
   // Residue classification codes.
   localparam logic [1:0] CLASS_ZERO    = 2'd0;
   localparam logic [1:0] CLASS_RESIDUE = 2'd1;
   localparam logic [1:0] CLASS_NONRES  = 2'd2;

   // Operation codes for the modular arithmetic unit.
   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_RED = 2'd1;
   typedef logic [1:0] op_type;

   // Command and status between sequencer and arithmetic unit.
   typedef struct packed {
      logic   start;
      op_type op;
   } mmu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mmu_sts_type;
endpackage
`default_nettype wire

[sv/msqrt_modmul.sv]
//------------------------------------------------------------------------------
// msqrt_modmul
// Bit-serial modular unit: x*y mod p by double-and-add, one multiplier bit a
// cycle, or reduction of a max(W,32)-bit magnitude mod p one bit a cycle.
//------------------------------------------------------------------------------
`default_nettype none
module msqrt_modmul #(
   parameter int W = 31
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire msqrt_pkg::mmu_cmd_type           cmd,
   input  wire logic [W-1:0]                     x,
   input  wire logic [W-1:0]                     p,
   input  wire logic [((W > 32) ? W : 32)-1:0]   y,
   output msqrt_pkg::mmu_sts_type                sts,
   output logic [W-1:0]                          result
);
   import msqrt_pkg::*;
   localparam int RW = (W > 32) ? W : 32;
   localparam int CW = $clog2(RW + 1);

   logic [RW-1:0] y_ff, y_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in, red_ff, red_in;
   logic [W:0]    dbl, dsub, add, asub;
   logic [W-1:0]  dbl_r, addend;

   // One step: acc = 2*acc (+ bit) mod p, then optionally + x mod p.
   always_comb begin
      dbl    = {acc_ff, red_ff ? y_ff[RW-1] : 1'b0};
      dsub   = dbl - {1'b0, p};
      dbl_r  = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
      addend = (!red_ff && y_ff[RW-1]) ? x_ff : '0;
      add    = {1'b0, dbl_r} + {1'b0, addend};
      asub   = add - {1'b0, p};
      y_in = y_ff; acc_in = acc_ff; x_in = x_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0; red_in = red_ff;
      if (cmd.start && !busy_ff) begin
         y_in = y; x_in = x; acc_in = '0; cnt_in = CW'(RW);
         busy_in = 1'b1; red_in = (cmd.op == OP_RED);
      end else if (busy_ff) begin
         acc_in = asub[W] ? add[W-1:0] : asub[W-1:0];
         y_in   = {y_ff[RW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in; acc_ff <= acc_in; x_ff <= x_in; cnt_ff <= cnt_in;
      red_ff <= red_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("done without work");
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && cnt_ff != CW'(1)) |=> busy_ff)
      else $error("early stop");
endmodule
`default_nettype wire

[sv/modular_square_root_unit.sv]
//------------------------------------------------------------------------------
// modular_square_root_unit
// Tonelli-Shanks modular square root with a bit-serial modular multiplier.
//------------------------------------------------------------------------------
// Moduli 0 and 1 answer in the cycle after the transfer; modulus 2 or a zero
// value answers after the reduction alone; a residue modulo a prime answers
// after Euler's test, the non-residue search and the correction loop, and each
// extra candidate tried in the non-residue search costs one more exponentiation.
// Throughput: one item at a time; the next is taken the cycle after the result.
// Reset: synchronous active-high reset returns the sequencer to idle.
`default_nettype none
module modular_square_root_unit #(
   parameter int MOD_WIDTH = 31
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // a_value [31:0], modulus [62:32], zero fill [63]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // root [30:0], has_root [31], residue_class [33:32], zero fill [39:34]
   output logic [39:0]      rsp_tdata
);
   import msqrt_pkg::*;
   localparam int W  = MOD_WIDTH;
   localparam int RW = (W > 32) ? W : 32;
   localparam int SW = $clog2(W + 1);

   localparam logic [4:0] ST_IDLE = 5'd0, ST_RED = 5'd1, ST_REDW = 5'd2,
      ST_EUL = 5'd3, ST_EULR = 5'd4, ST_FACT = 5'd5, ST_ZCHK = 5'd6,
      ST_ZNXT = 5'd7, ST_C = 5'd8, ST_T = 5'd9, ST_R = 5'd10, ST_LOOP = 5'd11,
      ST_SQB = 5'd12, ST_SQBW = 5'd13, ST_FIX = 5'd14, ST_FIXR = 5'd15,
      ST_FIXC = 5'd16, ST_FIXT = 5'd17, ST_SQC = 5'd18, ST_SQCW = 5'd19,
      ST_OUT = 5'd20, ST_POW = 5'd21, ST_PLOOP = 5'd22, ST_PACC = 5'd23,
      ST_PSQ = 5'd24, ST_PSQW = 5'd25, ST_WAIT = 5'd26;

   logic [4:0]    st_ff, st_in, ret_ff, ret_in, wret_ff, wret_in;
   logic [W-1:0]  p_ff, p_in, a_ff, a_in, q_ff, q_in, z_ff, z_in;
   logic [W-1:0]  c_ff, c_in, t_ff, t_in, r_ff, r_in, b_ff, b_in;
   logic [W-1:0]  pb_ff, pb_in, pacc_ff, pacc_in, pe_ff, pe_in, tmp_ff, tmp_in;
   logic [SW-1:0] s_ff, s_in, m_ff, m_in, k_ff, k_in;
   logic          neg_ff, neg_in;
   logic [31:0]   mag_ff, mag_in;
   logic [W-1:0]  root_ff, root_in;
   logic          has_ff, has_in;
   logic [1:0]    cls_ff, cls_in;
   logic [31:0]   araw, mag;
   logic [W-1:0]  pin, one_w, mx, my;
   logic [RW-1:0] mry;
   mmu_cmd_type   cmd;
   mmu_sts_type   sts;
   logic [W-1:0]  mres;

   assign araw  = req_tdata[31:0];
   assign pin   = W'(req_tdata[62:32]);
   assign one_w = W'(1);
   assign mag   = araw[31] ? (~araw + 32'd1) : araw;
   assign mry   = (cmd.op == OP_RED) ? RW'(mag_ff) : RW'(my);

   msqrt_modmul #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .cmd(cmd), .x(mx), .p(p_ff),
      .y(mry), .sts(sts), .result(mres)
   );

   // Sequencer: operands go to the multiplier in the cycle that starts it.
   always_comb begin
      st_in = st_ff; ret_in = ret_ff; wret_in = wret_ff;
      p_in = p_ff; a_in = a_ff; q_in = q_ff; z_in = z_ff; c_in = c_ff;
      t_in = t_ff; r_in = r_ff; b_in = b_ff; pb_in = pb_ff; pacc_in = pacc_ff;
      pe_in = pe_ff; tmp_in = tmp_ff; s_in = s_ff; m_in = m_ff; k_in = k_ff;
      neg_in = neg_ff; root_in = root_ff; has_in = has_ff; cls_in = cls_ff;
      mag_in = mag_ff;
      mx = '0; my = '0;
      cmd.start = 1'b0; cmd.op = OP_MUL;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               p_in = pin; neg_in = araw[31]; mag_in = mag;
               if (pin == '0) begin
                  root_in = '0; has_in = 1'b0; cls_in = CLASS_NONRES; st_in = ST_OUT;
               end else if (pin == one_w) begin
                  root_in = '0; has_in = 1'b1; cls_in = CLASS_ZERO; st_in = ST_OUT;
               end else begin
                  st_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            cmd.start = 1'b1; cmd.op = OP_RED; wret_in = ST_REDW; st_in = ST_WAIT;
         end
         ST_REDW: begin
            a_in = (neg_ff && tmp_ff != '0) ? p_ff - tmp_ff : tmp_ff;
            st_in = ST_EUL;
         end
         ST_EUL: begin
            if (p_ff == W'(2)) begin
               root_in = a_ff; has_in = 1'b1;
               cls_in = a_ff[0] ? CLASS_RESIDUE : CLASS_ZERO;
               st_in = ST_OUT;
            end else if (a_ff == '0) begin
               root_in = '0; has_in = 1'b1; cls_in = CLASS_ZERO; st_in = ST_OUT;
            end else begin
               pb_in = a_ff; pe_in = p_ff >> 1; ret_in = ST_EULR; st_in = ST_POW;
            end
         end
         ST_EULR: begin
            if (pacc_ff != one_w) begin
               root_in = '0; has_in = 1'b0; cls_in = CLASS_NONRES; st_in = ST_OUT;
            end else begin
               q_in = p_ff >> 1; s_in = SW'(1); st_in = ST_FACT;
            end
         end
         // Strip factors of two from (p-1)/2.
         ST_FACT: begin
            if (q_ff != '0 && !q_ff[0]) begin
               q_in = q_ff >> 1; s_in = s_ff + SW'(1);
            end else begin
               z_in = W'(2); st_in = ST_ZCHK;
            end
         end
         // Search upward for the first non-residue.
         ST_ZCHK: begin
            if (z_ff >= p_ff) begin
               root_in = '0; has_in = 1'b0; cls_in = CLASS_NONRES; st_in = ST_OUT;
            end else begin
               pb_in = z_ff; pe_in = p_ff >> 1; ret_in = ST_ZNXT; st_in = ST_POW;
            end
         end
         ST_ZNXT: begin
            if (pacc_ff != one_w) begin
               pb_in = z_ff; pe_in = q_ff; ret_in = ST_C; st_in = ST_POW;
            end else begin
               z_in = z_ff + one_w; st_in = ST_ZCHK;
            end
         end
         ST_C: begin
            c_in = pacc_ff; pb_in = a_ff; pe_in = q_ff; ret_in = ST_T; st_in = ST_POW;
         end
         ST_T: begin
            t_in = pacc_ff; pb_in = a_ff; pe_in = (q_ff + one_w) >> 1;
            ret_in = ST_R; st_in = ST_POW;
         end
         ST_R: begin
            r_in = pacc_ff; m_in = s_ff; st_in = ST_LOOP;
         end
         // Correction loop, m from s down to 2.
         ST_LOOP: begin
            if (m_ff > SW'(1)) begin
               b_in = t_ff; k_in = '0; st_in = ST_SQB;
            end else begin
               root_in = r_ff; has_in = 1'b1; cls_in = CLASS_RESIDUE; st_in = ST_OUT;
            end
         end
         ST_SQB: begin
            if (k_ff + SW'(2) >= m_ff) begin
               st_in = ST_FIX;
            end else begin
               mx = b_ff; my = b_ff; cmd.start = 1'b1;
               wret_in = ST_SQBW; st_in = ST_WAIT;
            end
         end
         ST_SQBW: begin
            b_in = tmp_ff; k_in = k_ff + SW'(1); st_in = ST_SQB;
         end
         ST_FIX: begin
            if (b_ff != one_w) begin
               mx = r_ff; my = c_ff; cmd.start = 1'b1;
               wret_in = ST_FIXR; st_in = ST_WAIT;
            end else begin
               st_in = ST_SQC;
            end
         end
         ST_FIXR: begin
            r_in = tmp_ff; mx = c_ff; my = c_ff; cmd.start = 1'b1;
            wret_in = ST_FIXC; st_in = ST_WAIT;
         end
         ST_FIXC: begin
            mx = tmp_ff; my = t_ff; cmd.start = 1'b1;
            wret_in = ST_FIXT; st_in = ST_WAIT;
         end
         ST_FIXT: begin
            t_in = tmp_ff; st_in = ST_SQC;
         end
         ST_SQC: begin
            mx = c_ff; my = c_ff; cmd.start = 1'b1;
            wret_in = ST_SQCW; st_in = ST_WAIT;
         end
         ST_SQCW: begin
            c_in = tmp_ff; m_in = m_ff - SW'(1); st_in = ST_LOOP;
         end
         // Square-and-multiply exponentiation, LSB first.
         ST_POW: begin
            pacc_in = one_w; st_in = ST_PLOOP;
         end
         ST_PLOOP: begin
            if (pe_ff == '0) begin
               st_in = ret_ff;
            end else if (pe_ff[0]) begin
               mx = pacc_ff; my = pb_ff; cmd.start = 1'b1;
               wret_in = ST_PACC; st_in = ST_WAIT;
            end else begin
               st_in = ST_PSQ;
            end
         end
         ST_PACC: begin
            pacc_in = tmp_ff; st_in = ST_PSQ;
         end
         ST_PSQ: begin
            mx = pb_ff; my = pb_ff; cmd.start = 1'b1;
            wret_in = ST_PSQW; st_in = ST_WAIT;
         end
         ST_PSQW: begin
            pb_in = tmp_ff; pe_in = pe_ff >> 1; st_in = ST_PLOOP;
         end
         ST_WAIT: begin
            if (sts.done) begin
               tmp_in = mres; st_in = wret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; a_ff <= a_in; q_ff <= q_in; z_ff <= z_in; c_ff <= c_in;
      t_ff <= t_in; r_ff <= r_in; b_ff <= b_in; pb_ff <= pb_in; pacc_ff <= pacc_in;
      pe_ff <= pe_in; tmp_ff <= tmp_in; s_ff <= s_in; m_ff <= m_in; k_ff <= k_in;
      neg_ff <= neg_in; root_ff <= root_in; has_ff <= has_in; cls_ff <= cls_in;
      mag_ff <= mag_in;
      if (reset) begin
         st_ff <= ST_IDLE; ret_ff <= ST_IDLE; wret_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; wret_ff <= wret_in;
      end
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = {6'd0, cls_ff, has_ff, 31'(root_ff)};

   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("accept during output");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && !has_ff) |-> root_ff == '0)
      else $error("root without existence");
   assert property (@(posedge clock) disable iff (reset) cmd.start |-> !sts.busy)
      else $error("start while multiplier busy");
endmodule
`default_nettype wire
